// ----- rtl/core/rflc_pkg.sv -----
// Shared types and constants for the RS-485 frame link controller.
package rflc_pkg;

  // Frame store geometry (depth is a power of two; read positions wrap)
  localparam int FRAME_DEPTH = 256;
  localparam int STORE_AW    = $clog2(FRAME_DEPTH);

  // Configuration register indexes
  localparam logic CFG_LINK_MODE = 1'b0;
  localparam logic CFG_GAP_TICKS = 1'b1;

  // Link modes
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_MODBUS = 3'd1;
  localparam logic [2:0] MODE_TEXT   = 3'd2;
  localparam logic [2:0] MODE_DEBUG  = 3'd3;
  localparam logic [2:0] MODE_MIXED  = 3'd4;

  localparam logic [7:0]  DEBUG_MARK = 8'h80;
  localparam logic [15:0] GAP_RESET  = 16'd2734;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_RX      = 3'd1,
    KIND_TX_DONE = 3'd2,
    KIND_SEND    = 3'd3,
    KIND_LOAD    = 3'd4,
    KIND_DEBUG   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABORT   = 3'd3,
    ST_REFUSED = 3'd4
  } status_t;

  // Access request to the frame store
  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
  } store_req_t;

endpackage

// ----- rtl/core/rflc_frame_store.sv -----
// Frame byte store: single write port, one registered read port.
module rflc_frame_store (
  input  logic                clk,
  input  rflc_pkg::store_req_t req,
  output logic [7:0]          rd_data
);

  logic [7:0] mem [rflc_pkg::FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    // read data holds between reads so a stalled result keeps its byte
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- rtl/core/rs485_frame_link_control_top.sv -----
// Top level of the half-duplex RS-485 frame link controller.
// Each result is registered and appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while out_stall holds no result; the single frame
// store read port and one-deep output register set this, the store read in the accept cycle.
// Reset (rst, synchronous): link state and handshakes clear, link_mode = 1,
// gap_ticks = 2734, receiver on. The frame store is not cleared.
module rs485_frame_link_control_top (
  input  logic        clk,
  input  logic        rst,

  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,

  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  data,
  input  logic [7:0]  slot,
  input  logic [7:0]  frame_length,

  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        rx_valid,
  output logic [7:0]  rx_byte,
  output logic        frame_end,
  output logic        drive_enable,
  output logic        receive_on,
  output logic [2:0]  send_status
);

  // configuration registers
  logic [2:0]  link_mode;
  logic [15:0] gap_ticks;

  // link state
  logic [7:0]  read_pos,      read_pos_next;
  logic [7:0]  bytes_left,    bytes_left_next;
  logic        tx_active,     tx_active_next;
  logic        driver_on,     driver_on_next;
  logic        rx_enabled,    rx_enabled_next;
  logic [7:0]  pending_debug, pending_debug_next;
  logic [15:0] gap_count,     gap_count_next;
  logic        gap_running,   gap_running_next;

  // result fields computed in the accept cycle
  logic              txv, rxv, fend, from_store;
  logic [7:0]        txb;
  rflc_pkg::status_t st;

  // output register
  logic       tx_from_store;
  logic [7:0] tx_byte_reg;
  logic [7:0] store_rd_data;
  logic [15:0] gap_inc;
  logic        accept;

  rflc_pkg::store_req_t store_req;

  // The output register is the only buffer; hold off input while a result waits.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // pending / mixed-mode debug chars get the mark unless in plain debug mode
  function automatic logic [7:0] mark_debug(input logic [2:0] mode, input logic [7:0] c);
    mark_debug = (mode == rflc_pkg::MODE_DEBUG) ? c : (c | rflc_pkg::DEBUG_MARK);
  endfunction

  assign gap_inc = (gap_count != 16'hFFFF) ? (gap_count + 16'd1) : gap_count;

  always_comb begin
    read_pos_next      = read_pos;
    bytes_left_next    = bytes_left;
    tx_active_next     = tx_active;
    driver_on_next     = driver_on;
    rx_enabled_next    = rx_enabled;
    pending_debug_next = pending_debug;
    gap_count_next     = gap_count;
    gap_running_next   = gap_running;
    txv        = 1'b0;
    txb        = 8'd0;
    rxv        = 1'b0;
    fend       = 1'b0;
    from_store = 1'b0;
    st         = rflc_pkg::ST_NONE;
    store_req  = '0;
    store_req.wr_addr = slot[rflc_pkg::STORE_AW-1:0];
    store_req.wr_data = data;
    store_req.rd_addr = read_pos[rflc_pkg::STORE_AW-1:0];

    unique case (rflc_pkg::kind_t'(kind))
      rflc_pkg::KIND_TICK: begin
        if (gap_running) begin
          if (gap_inc >= gap_ticks) begin
            fend             = 1'b1;
            gap_running_next = 1'b0;
            gap_count_next   = 16'd0;
          end else begin
            gap_count_next = gap_inc;
          end
        end
      end
      rflc_pkg::KIND_RX: begin
        if (rx_enabled) begin
          gap_count_next   = 16'd0;
          gap_running_next = 1'b1;
          rxv              = 1'b1;
        end
      end
      rflc_pkg::KIND_TX_DONE: begin
        if (tx_active) begin
          if (pending_debug != 8'd0) begin
            // queued debug char goes ahead of frame bytes
            txv                = 1'b1;
            txb                = mark_debug(link_mode, pending_debug);
            pending_debug_next = 8'd0;
          end else if (bytes_left != 8'd0) begin
            txv             = 1'b1;
            from_store      = 1'b1;
            store_req.rd_en = 1'b1;
            read_pos_next   = read_pos + 8'd1;
            bytes_left_next = bytes_left - 8'd1;
          end else begin
            // line goes quiet: release driver, receiver back on
            driver_on_next  = 1'b0;
            rx_enabled_next = 1'b1;
            tx_active_next  = 1'b0;
            st              = rflc_pkg::ST_DONE;
          end
        end
      end
      rflc_pkg::KIND_SEND: begin
        if (frame_length == 8'd0) begin
          st = rflc_pkg::ST_EMPTY;
        end else begin
          if (bytes_left != 8'd0) begin
            st = rflc_pkg::ST_ABORT;
          end
          // byte 0 goes out immediately
          txv               = 1'b1;
          from_store        = 1'b1;
          store_req.rd_en   = 1'b1;
          store_req.rd_addr = '0;
          read_pos_next     = 8'd1;
          bytes_left_next   = frame_length - 8'd1;
          tx_active_next    = 1'b1;
          driver_on_next    = 1'b1;
          rx_enabled_next   = 1'b0;
        end
      end
      rflc_pkg::KIND_LOAD: begin
        store_req.wr_en = ({1'b0, slot} < 9'(rflc_pkg::FRAME_DEPTH));
      end
      rflc_pkg::KIND_DEBUG: begin
        if (link_mode == rflc_pkg::MODE_TEXT) begin
          txv = 1'b1;
          txb = data;
        end else if (link_mode == rflc_pkg::MODE_DEBUG ||
                     link_mode == rflc_pkg::MODE_MIXED) begin
          if (!tx_active) begin
            tx_active_next = 1'b1;
            txv            = 1'b1;
            txb            = mark_debug(link_mode, data);
          end else if (pending_debug == 8'd0) begin
            // a NUL char lands here too and is effectively dropped
            pending_debug_next = data;
          end else begin
            st = rflc_pkg::ST_REFUSED;
          end
        end
      end
      default: begin
        // unused kinds: idle result
      end
    endcase

    if (!accept) begin
      store_req.wr_en = 1'b0;
      store_req.rd_en = 1'b0;
    end
  end

  rflc_frame_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (store_rd_data)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode <= rflc_pkg::MODE_MODBUS;
      gap_ticks <= rflc_pkg::GAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rflc_pkg::CFG_LINK_MODE: begin
          // out-of-range modes fall back to Modbus
          link_mode <= (cfg_data[2:0] > rflc_pkg::MODE_MIXED) ? rflc_pkg::MODE_MODBUS
                                                             : cfg_data[2:0];
        end
        rflc_pkg::CFG_GAP_TICKS: begin
          gap_ticks <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // link state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos      <= 8'd0;
      bytes_left    <= 8'd0;
      tx_active     <= 1'b0;
      driver_on     <= 1'b0;
      rx_enabled    <= 1'b1;
      pending_debug <= 8'd0;
      gap_count     <= 16'd0;
      gap_running   <= 1'b0;
    end else if (accept) begin
      read_pos      <= read_pos_next;
      bytes_left    <= bytes_left_next;
      tx_active     <= tx_active_next;
      driver_on     <= driver_on_next;
      rx_enabled    <= rx_enabled_next;
      pending_debug <= pending_debug_next;
      gap_count     <= gap_count_next;
      gap_running   <= gap_running_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload; the store byte arrives with the registered read data
  always_ff @(posedge clk) begin
    if (accept) begin
      tx_valid      <= txv;
      tx_byte_reg   <= txb;
      tx_from_store <= from_store;
      rx_valid      <= rxv;
      rx_byte       <= rxv ? data : 8'd0;
      frame_end     <= fend;
      send_status   <= st;
    end
  end

  assign tx_byte = tx_from_store ? store_rd_data : tx_byte_reg;

  // driver and receiver state only move on accept, so they match the held result
  assign drive_enable = driver_on;
  assign receive_on   = rx_enabled;

endmodule
